[src/oaht_pkg.sv]
package oaht_pkg;

  localparam int KEY_W  = 32;
  localparam int HASH_W = 32;
  localparam int VAL_W  = 32;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MK_EMPTY = 2'd0,
    MK_LIVE  = 2'd1,
    MK_TOMB  = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_CHECK
  } state_t;

  typedef struct packed {
    mark_t               mark;
    logic [HASH_W-1:0]   hash;
    logic [KEY_W-1:0]    key;
    logic [VAL_W-1:0]    value;
  } entry_t;

endpackage

[src/oaht_chan_if.sv]
interface oaht_in_if;
  import oaht_pkg::*;

  logic              valid;
  logic              ready;
  op_t               operation;
  logic [KEY_W-1:0]  key;
  logic [HASH_W-1:0] key_hash;
  logic [VAL_W-1:0]  value;

  modport source (output valid, operation, key, key_hash, value, input ready);
  modport sink   (input valid, operation, key, key_hash, value, output ready);
endinterface

interface oaht_out_if #(
  parameter int IDX_W = 10
);
  import oaht_pkg::*;

  logic             valid;
  logic             ready;
  status_t          status;
  logic [VAL_W-1:0] found_value;
  logic [IDX_W-1:0] slot_index;
  logic [IDX_W:0]   live_count;

  modport source (output valid, status, found_value, slot_index, live_count, input ready);
  modport sink   (input valid, status, found_value, slot_index, live_count, output ready);
endinterface

[src/open_addressing_hash_table.sv]
// Open-addressing key/value table with perturbed probing. Each input item is a lookup,
// an insert or update, a delete or a clear, and gives exactly one result item. All slots
// live in one single-port-read memory, so every probed slot takes a read state (S_PROBE),
// then a state that compares and steps to the next slot (S_CHECK); a probe visits at most
// TABLE_ENTRIES + 40 slots. A clear, and the pass that follows reset, sweeps the memory
// one slot a cycle with no item accepted; a clear's sweep holds at its last slot until
// the output register is free for its result. A finished result waits in the output
// register while the next item is taken. The output channel's IDX_W must equal log2(TABLE_ENTRIES).
module open_addressing_hash_table #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int PERTURB_SHIFT = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  oaht_in_if.sink        in_chan,
  oaht_out_if.source     out_chan
);
  import oaht_pkg::*;

  localparam int IDX_W       = $clog2(TABLE_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int PROBE_LIMIT = TABLE_ENTRIES + 40;
  localparam int STEP_W      = $clog2(PROBE_LIMIT);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_ENTRIES - 1);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_q;

  state_t state_r, state_nxt;

  op_t               op_r;
  logic [KEY_W-1:0]  key_r;
  logic [HASH_W-1:0] hash_r;
  logic [VAL_W-1:0]  val_r;

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [HASH_W-1:0] pert_r, pert_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              have_free_r, have_free_nxt;
  logic [IDX_W-1:0]  free_r, free_nxt;
  logic [IDX_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic              clr_report_r, clr_report_nxt;
  logic [CNT_W-1:0]  filled_r, filled_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [VAL_W-1:0]  out_fval_r;
  logic [IDX_W-1:0]  out_slot_r;
  logic [CNT_W-1:0]  out_live_r;

  logic              in_acc, out_free, out_load;
  status_t           res_status;
  logic [VAL_W-1:0]  res_fval;
  logic [IDX_W-1:0]  res_slot;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  entry_t            live_entry;

  logic              is_empty, is_tomb, is_hit, last_step, probe_end;
  logic              have_free_eff;
  logic [IDX_W-1:0]  free_eff, idx_step;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.found_value = out_fval_r;
  assign out_chan.slot_index  = out_slot_r;
  assign out_chan.live_count  = out_live_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[idx_r];
  end

  assign is_empty      = (rd_q.mark == MK_EMPTY);
  assign is_tomb       = (rd_q.mark == MK_TOMB);
  assign is_hit        = !is_empty && !is_tomb && (rd_q.hash == hash_r) && (rd_q.key == key_r);
  assign last_step     = (step_r == STEP_W'(PROBE_LIMIT - 1));
  assign probe_end     = is_hit || is_empty || last_step;
  assign have_free_eff = have_free_r || is_tomb;
  assign free_eff      = have_free_r ? free_r : idx_r;
  assign idx_step      = IDX_W'({idx_r, 2'b00}) + idx_r + IDX_W'(1) + pert_r[IDX_W-1:0];
  assign live_entry    = '{mark: MK_LIVE, hash: hash_r, key: key_r, value: val_r};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_chan.operation;
      key_r  <= in_chan.key;
      hash_r <= in_chan.key_hash;
      val_r  <= in_chan.value;
    end
    idx_r       <= idx_nxt;
    pert_r      <= pert_nxt;
    step_r      <= step_nxt;
    have_free_r <= have_free_nxt;
    free_r      <= free_nxt;
    if (out_load) begin
      out_status_r <= res_status;
      out_fval_r   <= res_fval;
      out_slot_r   <= res_slot;
      out_live_r   <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      clr_report_r <= 1'b0;
      filled_r     <= '0;
      used_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      clr_report_r <= clr_report_nxt;
      filled_r     <= filled_nxt;
      used_r       <= used_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pert_nxt       = pert_r;
    step_nxt       = step_r;
    have_free_nxt  = have_free_r;
    free_nxt       = free_r;
    clr_idx_nxt    = clr_idx_r;
    clr_report_nxt = clr_report_r;
    filled_nxt     = filled_r;
    used_nxt       = used_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = '{mark: MK_EMPTY, hash: '0, key: '0, value: '0};
    out_load       = 1'b0;
    res_status     = ST_OK;
    res_fval       = '0;
    res_slot       = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        if (clr_idx_r == IDX_MAX) begin
          if (!clr_report_r) begin
            state_nxt = S_IDLE;
          end else if (out_free) begin
            out_load       = 1'b1;
            clr_report_nxt = 1'b0;
            state_nxt      = S_IDLE;
          end
        end else begin
          clr_idx_nxt = clr_idx_r + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_chan.operation == OP_CLEAR) begin
            clr_idx_nxt    = '0;
            clr_report_nxt = 1'b1;
            filled_nxt     = '0;
            used_nxt       = '0;
            state_nxt      = S_CLEAR;
          end else begin
            idx_nxt       = in_chan.key_hash[IDX_W-1:0];
            pert_nxt      = in_chan.key_hash;
            step_nxt      = '0;
            have_free_nxt = 1'b0;
            state_nxt     = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!probe_end) begin
          // advance to the next slot, remembering the first tombstone
          if (is_tomb && !have_free_r) begin
            have_free_nxt = 1'b1;
            free_nxt      = idx_r;
          end
          idx_nxt   = idx_step;
          pert_nxt  = pert_r >> PERTURB_SHIFT;
          step_nxt  = step_r + STEP_W'(1);
          state_nxt = S_PROBE;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          case (op_r)
            OP_LOOKUP: begin
              if (is_hit) begin
                res_fval = rd_q.value;
                res_slot = idx_r;
              end else begin
                res_status = ST_MISS;
              end
            end
            OP_INSERT: begin
              if (is_hit) begin
                mem_we    = 1'b1;
                mem_waddr = idx_r;
                mem_wdata = live_entry;
                res_slot  = idx_r;
              end else if (!is_empty && !have_free_eff) begin
                res_status = ST_FULL;
              end else if (have_free_eff) begin
                mem_we    = 1'b1;
                mem_waddr = free_eff;
                mem_wdata = live_entry;
                used_nxt  = used_r + CNT_W'(1);
                res_slot  = free_eff;
              end else if (filled_r >= CNT_W'(TABLE_ENTRIES - 1)) begin
                res_status = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = idx_r;
                mem_wdata  = live_entry;
                filled_nxt = filled_r + CNT_W'(1);
                used_nxt   = used_r + CNT_W'(1);
                res_slot   = idx_r;
              end
            end
            OP_DELETE: begin
              if (is_hit) begin
                mem_we    = 1'b1;
                mem_waddr = idx_r;
                mem_wdata = '{mark: MK_TOMB, hash: hash_r, key: key_r, value: rd_q.value};
                if (used_r != '0) begin
                  used_nxt = used_r - CNT_W'(1);
                end
                res_slot = idx_r;
              end else begin
                res_status = ST_MISS;
              end
            end
            default: begin
              res_status = ST_OK;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_used_le_filled: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= filled_r)
    else $error("live count exceeds filled count");

  a_empty_slot_kept: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CNT_W'(TABLE_ENTRIES - 1))
    else $error("table left without an empty slot");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_CHECK))
    else $error("memory written outside sweep or probe end");

  a_full_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_status == ST_FULL) |-> (op_r == OP_INSERT))
    else $error("full status for an item that is not an insert");

  a_probe_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.operation != OP_CLEAR) |=> (state_r == S_PROBE))
    else $error("probe did not start after item accepted");

endmodule
